// ===== hw/rtl/bdt_pkg.sv =====
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared widths, constants and helpers for the calendar-to-seconds pipeline.
// ----------------------------------------------------------------------------
package bdt_pkg;

    localparam int NUM_STAGES = 6;

    // field widths
    localparam int YS_W   = 10;
    localparam int MON_W  = 8;
    localparam int MDAY_W = 6;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int SECS_W = 36;

    // internal widths
    localparam int Q12_W   = 5;   // month index / 12, 0..21
    localparam int MOY_W   = 4;   // month of year, 0..11
    localparam int YA_W    = 11;  // years since 1900 after carry, 0..1044
    localparam int Q100_W  = 4;   // ya / 100, 0..10
    localparam int Q400_W  = 2;   // (ya + 300) / 400, 0..3
    localparam int QTR_W   = 9;   // (ya + 32) / 4
    localparam int Y365_W  = 19;  // ya * 365
    localparam int DBM_W   = 9;   // days before month, 0..334
    localparam int DAYS_W  = 20;  // signed day count
    localparam int TSEC_W  = 18;  // signed seconds within the day, dst applied
    localparam int DSEC_W  = 18;  // signed width holding 86400

    // divide by 12 as multiply by 171 then shift by 11 (exact for 8-bit input)
    localparam int DIV12_MUL   = 171;
    localparam int DIV12_SHIFT = 11;
    localparam int DIV12_PW    = MON_W + 8;
    // divide by 100 as multiply by 41 then shift by 12 (exact below 1099)
    localparam int DIV100_MUL   = 41;
    localparam int DIV100_SHIFT = 12;
    localparam int DIV100_PW    = YA_W + 6;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int YEARS_PER_CENT  = 100;
    localparam int MARCH           = 2;

    // floor((year-1968)/4) = ((ya+32)>>2) - 25 ; floor((year-1600)/400) from ya+300
    localparam int QTR_OFFSET  = 32;
    localparam int Q400_OFFSET = 300;
    localparam int QUAD_CENT_1 = 400;
    localparam int QUAD_CENT_2 = 800;
    localparam int QUAD_CENT_3 = 1200;

    // -(70*365) - 25 (leap bias) - 1 (day of month is one-based)
    localparam int DAYS_BIAS = 25576;

    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_DAY  = 86400;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MOY_W-1:0] moy);
        logic [DBM_W-1:0] d;
        case (moy)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/bdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdt_ctrl
// Valid bits and per-stage load enables; a stage moves when it is empty or
// the stage after it moves.
// ----------------------------------------------------------------------------
module bdt_ctrl
    import bdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       res_valid,
    input  logic       res_stall,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !res_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = req_valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign ctrl.load = load;
    assign req_stall = !load[0];
    assign res_valid = valid_reg[NUM_STAGES-1];

endmodule

// ===== hw/rtl/bdt_date.sv =====
// ----------------------------------------------------------------------------
// bdt_date
// Stages 1 to 4: month carry, leap corrections and day count; also the
// seconds within the day.
// ----------------------------------------------------------------------------
module bdt_date
    import bdt_pkg::*;
(
    input  logic                     clk,
    input  pipe_ctrl_t               ctrl,
    input  logic [YS_W-1:0]          years_since_1900,
    input  logic [MON_W-1:0]         month_index,
    input  logic [MDAY_W-1:0]        day_of_month,
    input  logic [HOUR_W-1:0]        hour_of_day,
    input  logic [MIN_W-1:0]         minute_of_hour,
    input  logic [SEC_W-1:0]         second_of_minute,
    input  logic                     daylight_flag,
    output logic signed [DAYS_W-1:0] days,
    output logic signed [TSEC_W-1:0] tsec
);

    // stage 1: month / 12
    logic [DIV12_PW-1:0] div12_prod;
    logic [Q12_W-1:0]    s1_q12_next;
    logic [Q12_W-1:0]    s1_q12_reg;
    logic [YS_W-1:0]     s1_ys_reg;
    logic [MON_W-1:0]    s1_mon_reg;
    logic [MDAY_W-1:0]   s1_mday_reg;
    logic [HOUR_W-1:0]   s1_hour_reg;
    logic [MIN_W-1:0]    s1_min_reg;
    logic [SEC_W-1:0]    s1_sec_reg;
    logic                s1_dst_reg;

    assign div12_prod  = DIV12_PW'(month_index) * DIV12_PW'(DIV12_MUL);
    assign s1_q12_next = Q12_W'(div12_prod >> DIV12_SHIFT);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_q12_reg  <= s1_q12_next;
            s1_ys_reg   <= years_since_1900;
            s1_mon_reg  <= month_index;
            s1_mday_reg <= day_of_month;
            s1_hour_reg <= hour_of_day;
            s1_min_reg  <= minute_of_hour;
            s1_sec_reg  <= second_of_minute;
            s1_dst_reg  <= daylight_flag;
        end
    end

    // stage 2: carried year, month of year, time of day
    logic [YA_W-1:0]   s2_ya_next;
    logic [MOY_W-1:0]  s2_moy_next;
    logic [TSEC_W-1:0] s2_tsec_next;
    logic [YA_W-1:0]   s2_ya_reg;
    logic [MOY_W-1:0]  s2_moy_reg;
    logic [MDAY_W-1:0] s2_mday_reg;
    logic [TSEC_W-1:0] s2_tsec_reg;

    assign s2_ya_next  = YA_W'(s1_ys_reg) + YA_W'(s1_q12_reg);
    assign s2_moy_next = MOY_W'(s1_mon_reg - MON_W'(s1_q12_reg) * MON_W'(MONTHS_PER_YEAR));
    assign s2_tsec_next = TSEC_W'(s1_hour_reg) * TSEC_W'(SECS_PER_HOUR)
                        + TSEC_W'(s1_min_reg) * TSEC_W'(SECS_PER_MIN)
                        + TSEC_W'(s1_sec_reg)
                        - (s1_dst_reg ? TSEC_W'(SECS_PER_HOUR) : TSEC_W'(0));

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            s2_ya_reg   <= s2_ya_next;
            s2_moy_reg  <= s2_moy_next;
            s2_mday_reg <= s1_mday_reg;
            s2_tsec_reg <= s2_tsec_next;
        end
    end

    // stage 3: year terms and century quotients
    logic [DIV100_PW-1:0] div100_prod;
    logic [YA_W-1:0]      q400_arg;
    logic [YA_W-1:0]      qtr_arg;
    logic [Q100_W-1:0]    s3_q100_next;
    logic [Q400_W-1:0]    s3_q400_next;
    logic                 s3_quad_next;
    logic [Y365_W-1:0]    s3_y365_reg;
    logic [QTR_W-1:0]     s3_qtr_reg;
    logic [Q100_W-1:0]    s3_q100_reg;
    logic [Q400_W-1:0]    s3_q400_reg;
    logic                 s3_quad_reg;
    logic [DBM_W-1:0]     s3_dbm_reg;
    logic                 s3_janfeb_reg;
    logic [YA_W-1:0]      s3_ya_reg;
    logic [MDAY_W-1:0]    s3_mday_reg;
    logic [TSEC_W-1:0]    s3_tsec_reg;

    assign div100_prod  = DIV100_PW'(s2_ya_reg) * DIV100_PW'(DIV100_MUL);
    assign s3_q100_next = Q100_W'(div100_prod >> DIV100_SHIFT);
    assign q400_arg     = s2_ya_reg + YA_W'(Q400_OFFSET);
    assign qtr_arg      = s2_ya_reg + YA_W'(QTR_OFFSET);
    assign s3_q400_next = Q400_W'(q400_arg >= YA_W'(QUAD_CENT_1))
                        + Q400_W'(q400_arg >= YA_W'(QUAD_CENT_2))
                        + Q400_W'(q400_arg >= YA_W'(QUAD_CENT_3));
    // year divisible by 400
    assign s3_quad_next = (q400_arg == YA_W'(QUAD_CENT_1)) ||
                          (q400_arg == YA_W'(QUAD_CENT_2)) ||
                          (q400_arg == YA_W'(QUAD_CENT_3));

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            s3_y365_reg   <= Y365_W'(s2_ya_reg) * Y365_W'(DAYS_PER_YEAR);
            s3_qtr_reg    <= QTR_W'(qtr_arg >> 2);
            s3_q100_reg   <= s3_q100_next;
            s3_q400_reg   <= s3_q400_next;
            s3_quad_reg   <= s3_quad_next;
            s3_dbm_reg    <= days_before_month(s2_moy_reg);
            s3_janfeb_reg <= s2_moy_reg < MOY_W'(MARCH);
            s3_ya_reg     <= s2_ya_reg;
            s3_mday_reg   <= s2_mday_reg;
            s3_tsec_reg   <= s2_tsec_reg;
        end
    end

    // stage 4: leap test and day sum
    logic              cent_exact;
    logic              leap_year;
    logic [DAYS_W-1:0] s4_days_next;
    logic [DAYS_W-1:0] s4_days_reg;
    logic [TSEC_W-1:0] s4_tsec_reg;

    assign cent_exact = s3_ya_reg == YA_W'(s3_q100_reg) * YA_W'(YEARS_PER_CENT);
    assign leap_year  = (s3_ya_reg[1:0] == 2'b00) && (!cent_exact || s3_quad_reg);

    assign s4_days_next = DAYS_W'(s3_y365_reg) + DAYS_W'(s3_dbm_reg)
                        + DAYS_W'(s3_qtr_reg) - DAYS_W'(s3_q100_reg)
                        + DAYS_W'(s3_q400_reg) + DAYS_W'(s3_mday_reg)
                        - DAYS_W'(leap_year && s3_janfeb_reg)
                        - DAYS_W'(DAYS_BIAS);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            s4_days_reg <= s4_days_next;
            s4_tsec_reg <= s3_tsec_reg;
        end
    end

    assign days = $signed(s4_days_reg);
    assign tsec = $signed(s4_tsec_reg);

endmodule

// ===== hw/rtl/bdt_scale.sv =====
// ----------------------------------------------------------------------------
// bdt_scale
// Stages 5 and 6: days to seconds, then add the time of day.
// ----------------------------------------------------------------------------
module bdt_scale
    import bdt_pkg::*;
(
    input  logic                     clk,
    input  pipe_ctrl_t               ctrl,
    input  logic signed [DAYS_W-1:0] days,
    input  logic signed [TSEC_W-1:0] tsec,
    output logic signed [SECS_W-1:0] epoch_seconds
);

    localparam logic signed [DSEC_W-1:0] DAY_SECS = DSEC_W'(SECS_PER_DAY);

    logic signed [DAYS_W+DSEC_W-1:0] full_prod;
    logic signed [SECS_W-1:0]        s5_prod_reg;
    logic signed [TSEC_W-1:0]        s5_tsec_reg;
    logic signed [SECS_W-1:0]        s6_secs_reg;

    assign full_prod = days * DAY_SECS;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            s5_prod_reg <= full_prod[SECS_W-1:0];
            s5_tsec_reg <= tsec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            s6_secs_reg <= s5_prod_reg + SECS_W'(s5_tsec_reg);
        end
    end

    assign epoch_seconds = s6_secs_reg;

endmodule

// ===== hw/rtl/broken_down_time_to_epoch_seconds_unit.sv =====
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_seconds_unit
// UTC broken-down calendar time to signed seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_valid / req_stall with one calendar time per
//   request (years since 1900, month index, day, hour, minute, second,
//   daylight flag). Result channel: res_valid / res_stall with one
//   36-bit signed epoch_seconds per request, in request order.
//   Throughput: one request per cycle unless stalled; six register stages,
//   the limit set by the days-to-seconds multiplier and the day-sum adder.
//   Month indices of 12 or more carry into the year; day, hour, minute and
//   second add linearly; years before 1970 use floor leap corrections.
//   Reset (rst_n low, asynchronous) empties the pipe: all valid bits clear.
//   When res_stall is high the result holds; stages fill up behind it and
//   req_stall rises only once every stage is occupied. Nothing is dropped.
// ----------------------------------------------------------------------------
module broken_down_time_to_epoch_seconds_unit
    import bdt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [YS_W-1:0]          years_since_1900,
    input  logic [MON_W-1:0]         month_index,
    input  logic [MDAY_W-1:0]        day_of_month,
    input  logic [HOUR_W-1:0]        hour_of_day,
    input  logic [MIN_W-1:0]         minute_of_hour,
    input  logic [SEC_W-1:0]         second_of_minute,
    input  logic                     daylight_flag,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic signed [SECS_W-1:0] epoch_seconds
);

    pipe_ctrl_t               ctrl;
    logic signed [DAYS_W-1:0] days;
    logic signed [TSEC_W-1:0] tsec;

    // valid chain and stage enables
    bdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctrl      (ctrl)
    );

    // stages 1-4: day count and time of day
    bdt_date u_date (
        .clk              (clk),
        .ctrl             (ctrl),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .daylight_flag    (daylight_flag),
        .days             (days),
        .tsec             (tsec)
    );

    // stages 5-6: scale and sum
    bdt_scale u_scale (
        .clk           (clk),
        .ctrl          (ctrl),
        .days          (days),
        .tsec          (tsec),
        .epoch_seconds (epoch_seconds)
    );

endmodule

// ===== hw/rtl/bdt_checker.sv =====
// ----------------------------------------------------------------------------
// bdt_checker
// Port-level checks on the conversion unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdt_checker
    import bdt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_stall,
    input logic                     res_valid,
    input logic                     res_stall,
    input logic signed [SECS_W-1:0] epoch_seconds
);

    // a held result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(epoch_seconds))
        else $error("result changed while stalled");

    // back-pressure only when the pipe is full behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stalled with pipe not blocked");

    // an accepted request yields a valid result when the output drains freely
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall
            ##1 !res_stall ##1 !res_stall |=> res_valid)
        else $error("result missing after pipeline latency");

    // pipe empty straight after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !res_valid)
        else $error("result valid straight after reset");

endmodule

bind broken_down_time_to_epoch_seconds_unit bdt_checker u_bdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .epoch_seconds (epoch_seconds)
);
